// ----- design/multi_channel_byte_fifo_unit_defines.svh -----
// Assertion macros for the channel FIFO block.
`ifndef MULTI_CHANNEL_BYTE_FIFO_UNIT_DEFINES_SVH
`define MULTI_CHANNEL_BYTE_FIFO_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// ante |-> cons, sampled on clk, quiet while rst_n is low
`define MCBF_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);
// ante |=> cons, sampled on clk, quiet while rst_n is low
`define MCBF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);
`else
`define MCBF_ASSERT(lbl, clk, rst_n, ante, cons, msg)
`define MCBF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- design/mcbf_pkg.sv -----
package mcbf_pkg;

	localparam int NUM_CHANNELS = 16;
	localparam int RING_DEPTH   = 256;
	localparam int MAX_BURST    = 64;

	// only channels addressable by the 4-bit index are ever held
	localparam int TAB_N   = (NUM_CHANNELS < 16) ? NUM_CHANNELS : 16;
	localparam int TAB_AW  = (TAB_N > 1) ? $clog2(TAB_N) : 1;
	localparam int PTR_W   = $clog2(RING_DEPTH);
	localparam int CNT_W   = PTR_W + 1;
	localparam int CMP_W   = (CNT_W > 7) ? CNT_W : 7;
	localparam int RING_N  = TAB_N * RING_DEPTH;
	localparam int RING_AW = $clog2(RING_N);

	typedef enum logic [1:0] {
		CMD_ALLOC   = 2'd0,
		CMD_RELEASE = 2'd1,
		CMD_WRITE   = 2'd2,
		CMD_READ    = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		STAT_OK       = 3'd0,
		STAT_NO_FREE  = 3'd1,
		STAT_NOT_OPEN = 3'd2,
		STAT_FULL     = 3'd3,
		STAT_EMPTY    = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_EXEC = 2'd1,
		S_RD   = 2'd2
	} state_t;

	typedef struct packed {
		logic [PTR_W-1:0] head;
		logic [CNT_W-1:0] count;
	} chan_ent_t;

	typedef struct packed {
		logic      rd_en;
		logic [3:0] rd_ch;
		logic      wr_en;
		logic      set_open;
		logic      clr_open;
		logic [3:0] wr_ch;
		chan_ent_t wr_ent;
	} tab_req_t;

	typedef struct packed {
		logic [15:0] open;
		logic        free_found;
		logic [3:0]  free_ch;
		chan_ent_t   ent;
	} tab_stat_t;

	typedef struct packed {
		logic               we;
		logic [RING_AW-1:0] waddr;
		logic [7:0]         wdata;
		logic               re;
		logic [RING_AW-1:0] raddr;
	} ring_req_t;

	typedef struct packed {
		status_t    status;
		logic [3:0] channel;
		logic [7:0] data;
		logic [8:0] fill;
		logic       last;
	} result_t;

	// flat ring address of slot pos in channel ch
	function automatic logic [RING_AW-1:0] ring_addr(input logic [3:0] ch,
		input logic [PTR_W-1:0] pos);
		logic [RING_AW-1:0] base;
		base = RING_AW'(ch) * RING_AW'(RING_DEPTH);
		return base + RING_AW'(pos);
	endfunction

endpackage

// ----- design/mcbf_chan_tab.sv -----
module mcbf_chan_tab (
	input  logic                clk,
	input  logic                arst_n,
	input  mcbf_pkg::tab_req_t  req,
	output mcbf_pkg::tab_stat_t stat
);

	logic [mcbf_pkg::TAB_N-1:0]  open_q;
	mcbf_pkg::chan_ent_t         tab_mem [mcbf_pkg::TAB_N];
	mcbf_pkg::chan_ent_t         rd_q;
	logic [mcbf_pkg::TAB_AW-1:0] wr_idx;
	logic [mcbf_pkg::TAB_AW-1:0] rd_idx;
	logic                        found;
	logic [3:0]                  free_ch;

	assign wr_idx = req.wr_ch[mcbf_pkg::TAB_AW-1:0];
	assign rd_idx = req.rd_ch[mcbf_pkg::TAB_AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else begin
			if (req.set_open) begin
				open_q[wr_idx] <= 1'b1;
			end
			if (req.clr_open) begin
				open_q[wr_idx] <= 1'b0;
			end
		end
	end

	// head/count table, registered read
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			tab_mem[wr_idx] <= req.wr_ent;
		end
		if (req.rd_en) begin
			rd_q <= tab_mem[rd_idx];
		end
	end

	// lowest closed channel
	always_comb begin
		found   = 1'b0;
		free_ch = '0;
		for (int i = mcbf_pkg::TAB_N - 1; i >= 0; i--) begin
			if (!open_q[i]) begin
				found   = 1'b1;
				free_ch = 4'(i);
			end
		end
	end

	assign stat.open       = 16'(open_q);
	assign stat.free_found = found;
	assign stat.free_ch    = free_ch;
	assign stat.ent        = rd_q;

endmodule

// ----- design/mcbf_ring.sv -----
module mcbf_ring (
	input  logic                clk,
	input  mcbf_pkg::ring_req_t req,
	output logic [7:0]          rd_data
);

	logic [7:0] ring_mem [mcbf_pkg::RING_N];
	logic [7:0] rd_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			ring_mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rd_q <= ring_mem[req.raddr];
		end
	end

	assign rd_data = rd_q;

endmodule

// ----- design/mcbf_engine.sv -----
`include "multi_channel_byte_fifo_unit_defines.svh"

module mcbf_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  mcbf_pkg::cmd_t      in_cmd,
	input  logic [3:0]          in_ch,
	input  logic [7:0]          in_data,
	input  logic [6:0]          in_len,
	output mcbf_pkg::tab_req_t  tab_req,
	input  mcbf_pkg::tab_stat_t tab_stat,
	output mcbf_pkg::ring_req_t ring_req,
	input  logic [7:0]          ring_rd_data,
	input  logic                out_free,
	output logic                emit,
	output mcbf_pkg::result_t   result
);

	mcbf_pkg::state_t  state_q, state_d;
	mcbf_pkg::cmd_t    cmd_q;
	logic [3:0]        ch_q;
	logic [7:0]        data_q;
	logic [6:0]        len_q;
	logic [mcbf_pkg::PTR_W-1:0] head_q;
	logic [mcbf_pkg::CNT_W-1:0] cnt_q;
	logic [6:0]        rem_q;

	logic              accept;
	logic [6:0]        len_sat;
	logic              ch_open;
	mcbf_pkg::chan_ent_t ent;
	logic              full;
	logic [mcbf_pkg::CNT_W-1:0] wr_sum;
	logic [mcbf_pkg::PTR_W-1:0] wr_pos;
	logic [mcbf_pkg::CNT_W-1:0] cnt_inc;
	logic [mcbf_pkg::PTR_W-1:0] head_inc;
	logic [mcbf_pkg::CNT_W-1:0] cnt_dec;
	logic              last_byte;
	logic [6:0]        rem_init;
	logic              rd_go;
	logic              rd_step;

	assign accept  = in_valid && in_ready;
	assign len_sat = (in_len == 7'd0) ? 7'd1 :
		(in_len > 7'(mcbf_pkg::MAX_BURST)) ? 7'(mcbf_pkg::MAX_BURST) : in_len;

	assign ch_open = tab_stat.open[ch_q];
	assign ent     = tab_stat.ent;
	assign full    = (ent.count >= mcbf_pkg::CNT_W'(mcbf_pkg::RING_DEPTH));
	assign cnt_inc = ent.count + 1'b1;

	// tail slot = (head + count) mod depth, sum stays below twice the depth
	assign wr_sum = mcbf_pkg::CNT_W'(ent.head) + ent.count;
	assign wr_pos = (wr_sum >= mcbf_pkg::CNT_W'(mcbf_pkg::RING_DEPTH)) ?
		mcbf_pkg::PTR_W'(wr_sum - mcbf_pkg::CNT_W'(mcbf_pkg::RING_DEPTH)) :
		mcbf_pkg::PTR_W'(wr_sum);

	assign head_inc = (mcbf_pkg::CNT_W'(head_q) + mcbf_pkg::CNT_W'(1) ==
		mcbf_pkg::CNT_W'(mcbf_pkg::RING_DEPTH)) ? '0 : head_q + 1'b1;
	assign cnt_dec   = cnt_q - 1'b1;
	assign last_byte = (rem_q == 7'd1);
	assign rem_init  = (mcbf_pkg::CMP_W'(ent.count) < mcbf_pkg::CMP_W'(len_q)) ?
		7'(ent.count) : len_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			mcbf_pkg::S_IDLE: begin
				if (accept) begin
					state_d = mcbf_pkg::S_EXEC;
				end
			end
			mcbf_pkg::S_EXEC: begin
				if (out_free) begin
					if (cmd_q == mcbf_pkg::CMD_READ && ch_open && ent.count != '0) begin
						state_d = mcbf_pkg::S_RD;
					end else begin
						state_d = mcbf_pkg::S_IDLE;
					end
				end
			end
			mcbf_pkg::S_RD: begin
				if (out_free && last_byte) begin
					state_d = mcbf_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = mcbf_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready      = 1'b0;
		tab_req       = '0;
		tab_req.rd_ch = in_ch;
		ring_req      = '0;
		emit          = 1'b0;
		result        = '0;
		rd_go         = 1'b0;
		rd_step       = 1'b0;
		case (state_q)
			mcbf_pkg::S_IDLE: begin
				in_ready      = 1'b1;
				tab_req.rd_en = in_valid;
			end
			mcbf_pkg::S_EXEC: begin
				if (out_free) begin
					result.last    = 1'b1;
					result.channel = ch_q;
					if (cmd_q == mcbf_pkg::CMD_ALLOC) begin
						emit = 1'b1;
						if (tab_stat.free_found) begin
							tab_req.set_open = 1'b1;
							tab_req.wr_en    = 1'b1;
							tab_req.wr_ch    = tab_stat.free_ch;
							result.channel   = tab_stat.free_ch;
						end else begin
							result.status  = mcbf_pkg::STAT_NO_FREE;
							result.channel = 4'd0;
						end
					end else if (!ch_open) begin
						emit          = 1'b1;
						result.status = mcbf_pkg::STAT_NOT_OPEN;
					end else begin
						case (cmd_q)
							mcbf_pkg::CMD_RELEASE: begin
								emit             = 1'b1;
								tab_req.clr_open = 1'b1;
								tab_req.wr_ch    = ch_q;
							end
							mcbf_pkg::CMD_WRITE: begin
								emit = 1'b1;
								if (full) begin
									result.status = mcbf_pkg::STAT_FULL;
									result.fill   = 9'(ent.count);
								end else begin
									ring_req.we          = 1'b1;
									ring_req.waddr       = mcbf_pkg::ring_addr(ch_q, wr_pos);
									ring_req.wdata       = data_q;
									tab_req.wr_en        = 1'b1;
									tab_req.wr_ch        = ch_q;
									tab_req.wr_ent.head  = ent.head;
									tab_req.wr_ent.count = cnt_inc;
									result.fill          = 9'(cnt_inc);
								end
							end
							mcbf_pkg::CMD_READ: begin
								if (ent.count == '0) begin
									emit          = 1'b1;
									result.status = mcbf_pkg::STAT_EMPTY;
								end else begin
									ring_req.re    = 1'b1;
									ring_req.raddr = mcbf_pkg::ring_addr(ch_q, ent.head);
									rd_go          = 1'b1;
								end
							end
							default: begin
								emit = 1'b0;
							end
						endcase
					end
				end
			end
			mcbf_pkg::S_RD: begin
				if (out_free) begin
					emit           = 1'b1;
					rd_step        = 1'b1;
					result.channel = ch_q;
					result.data    = ring_rd_data;
					result.fill    = 9'(cnt_dec);
					result.last    = last_byte;
					if (last_byte) begin
						tab_req.wr_en        = 1'b1;
						tab_req.wr_ch        = ch_q;
						tab_req.wr_ent.head  = head_inc;
						tab_req.wr_ent.count = cnt_dec;
					end else begin
						ring_req.re    = 1'b1;
						ring_req.raddr = mcbf_pkg::ring_addr(ch_q, head_inc);
					end
				end
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mcbf_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= in_cmd;
			ch_q   <= in_ch;
			data_q <= in_data;
			len_q  <= len_sat;
		end
		if (rd_go) begin
			head_q <= ent.head;
			cnt_q  <= ent.count;
			rem_q  <= rem_init;
		end else if (rd_step) begin
			head_q <= head_inc;
			cnt_q  <= cnt_dec;
			rem_q  <= rem_q - 7'd1;
		end
	end

	`MCBF_ASSERT(a_emit_slot_free, clk, arst_n, emit, out_free, "result emitted into busy output slot")
	`MCBF_ASSERT_NEXT(a_accept_exec, clk, arst_n, accept, state_q == mcbf_pkg::S_EXEC, "accepted transfer not executed")
	`MCBF_ASSERT(a_no_write_full, clk, arst_n, ring_req.we, !full, "ring write into full channel")
	`MCBF_ASSERT(a_burst_nonzero, clk, arst_n, state_q == mcbf_pkg::S_RD, rem_q != 7'd0, "burst running with nothing left")

endmodule

// ----- design/multi_channel_byte_fifo_unit.sv -----
// Byte queue engine: up to 16 channels, each a ring of RING_DEPTH bytes.
// Input channel (s_*): one transfer is one command. s_tuser carries the
// command (allocate, release, write byte, read burst); s_tdata the channel,
// the byte to write and the burst length.
// Output channel (m_*): one transfer per result. m_tuser is the status,
// m_tdata the channel, popped byte and fill level, m_tlast marks the final
// result of a command. Non-read commands and failed reads give one result.
// Timing: a command is taken while the engine is idle, its channel entry is
// read from the head/count table as it is taken, and its result is written
// to the output register once that register is free (a read burst first
// reads the ring before its first byte). No new command is accepted until
// the engine is back in idle. A read burst streams one byte a cycle from
// the ring memory port while the output register is free.
// Throughput is set by the read-modify-write of the channel table, which
// also keeps back-to-back accesses to the same entry in order.
// Reset closes every channel; ring contents are left as they are and no
// clearing pass is needed. When m_tready is low the result stays in the
// output register and the engine waits, mid-burst included.
module multi_channel_byte_fifo_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // [3:0] channel, [11:4] data_in, [18:12] read_len, rest zero
	input  logic [1:0]  s_tuser,  // [1:0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // [3:0] channel_out, [11:4] data_out, [20:12] fill_level
	output logic [2:0]  m_tuser,  // [2:0] status
	output logic        m_tlast
);

	mcbf_pkg::tab_req_t  tab_req;
	mcbf_pkg::tab_stat_t tab_stat;
	mcbf_pkg::ring_req_t ring_req;
	logic [7:0]          ring_rd_data;
	logic                emit;
	mcbf_pkg::result_t   result;
	mcbf_pkg::result_t   result_q;
	logic                out_valid_q;
	logic                out_free;

	// output register frees as soon as the downstream takes the transfer
	assign out_free = !out_valid_q || m_tready;

	mcbf_engine u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.in_cmd       (mcbf_pkg::cmd_t'(s_tuser)),
		.in_ch        (s_tdata[3:0]),
		.in_data      (s_tdata[11:4]),
		.in_len       (s_tdata[18:12]),
		.tab_req      (tab_req),
		.tab_stat     (tab_stat),
		.ring_req     (ring_req),
		.ring_rd_data (ring_rd_data),
		.out_free     (out_free),
		.emit         (emit),
		.result       (result)
	);

	mcbf_chan_tab u_chan_tab (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (tab_req),
		.stat   (tab_stat)
	);

	mcbf_ring u_ring (
		.clk     (clk),
		.req     (ring_req),
		.rd_data (ring_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			result_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, result_q.fill, result_q.data, result_q.channel};
	assign m_tuser  = result_q.status;
	assign m_tlast  = result_q.last;

endmodule

// ----- verif/channel_tracker_pkg.sv -----
`timescale 1ns / 100ps

package channel_tracker_pkg;
	import mcbf_pkg::*;

	typedef struct {
		status_t    status;
		logic [3:0] channel;
		logic [7:0] data;
		logic [8:0] fill;
		logic       last;
	} chan_result_t;

	// Mirrors the channel table and rings, and holds the results still owed by the block.
	class channel_result_tracker;
		bit           is_open_q[NUM_CHANNELS];
		int           head_q[NUM_CHANNELS];
		int           count_q[NUM_CHANNELS];
		logic [7:0]   ring_q[NUM_CHANNELS][RING_DEPTH];
		chan_result_t due_q[$];
		int           failures;
		int           matched;
		int           status_hits[5];

		function void queue_result(status_t st, logic [3:0] ch, logic [7:0] d,
			logic [8:0] f, logic l);
			chan_result_t r;
			r.status  = st;
			r.channel = ch;
			r.data    = d;
			r.fill    = f;
			r.last    = l;
			due_q.push_back(r);
		endfunction

		// accepted command: update the mirror and queue what it should produce
		function void take_command(cmd_t cmd, logic [3:0] ch, logic [7:0] din,
			logic [6:0] rlen);
			int         c;
			int         n;
			int         slot;
			logic [7:0] popped;
			c = int'(ch);
			if (cmd == CMD_ALLOC) begin
				for (int i = 0; i < TAB_N; i++) begin
					if (!is_open_q[i]) begin
						is_open_q[i] = 1'b1;
						head_q[i]    = 0;
						count_q[i]   = 0;
						queue_result(STAT_OK, 4'(i), 8'd0, 9'd0, 1'b1);
						return;
					end
				end
				queue_result(STAT_NO_FREE, 4'd0, 8'd0, 9'd0, 1'b1);
				return;
			end
			if (c >= NUM_CHANNELS || !is_open_q[c]) begin
				queue_result(STAT_NOT_OPEN, ch, 8'd0, 9'd0, 1'b1);
				return;
			end
			case (cmd)
				CMD_RELEASE: begin
					is_open_q[c] = 1'b0;
					head_q[c]    = 0;
					count_q[c]   = 0;
					queue_result(STAT_OK, ch, 8'd0, 9'd0, 1'b1);
				end
				CMD_WRITE: begin
					if (count_q[c] >= RING_DEPTH) begin
						queue_result(STAT_FULL, ch, 8'd0, 9'(count_q[c]), 1'b1);
					end else begin
						slot = (head_q[c] + count_q[c]) % RING_DEPTH;
						ring_q[c][slot] = din;
						count_q[c]++;
						queue_result(STAT_OK, ch, 8'd0, 9'(count_q[c]), 1'b1);
					end
				end
				default: begin
					n = (rlen == 7'd0) ? 1 : int'(rlen);
					if (n > MAX_BURST)
						n = MAX_BURST;
					if (count_q[c] == 0) begin
						queue_result(STAT_EMPTY, ch, 8'd0, 9'd0, 1'b1);
					end else begin
						if (n > count_q[c])
							n = count_q[c];
						for (int k = 0; k < n; k++) begin
							popped    = ring_q[c][head_q[c]];
							head_q[c] = (head_q[c] + 1) % RING_DEPTH;
							count_q[c]--;
							queue_result(STAT_OK, ch, popped, 9'(count_q[c]), k == n - 1);
						end
					end
				end
			endcase
		endfunction

		// result transfer from the block: compare with the oldest one owed
		function void match_result(logic [2:0] st, logic [3:0] ch, logic [7:0] d,
			logic [8:0] f, logic l);
			chan_result_t e;
			if (due_q.size() == 0) begin
				$error("result with nothing due: status %0d channel_out %0d data_out %0h",
					st, ch, d);
				failures++;
				return;
			end
			e = due_q.pop_front();
			matched++;
			status_hits[e.status]++;
			if (st !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, st);
				failures++;
			end
			if (ch !== e.channel) begin
				$error("channel_out: expected %0d, got %0d", e.channel, ch);
				failures++;
			end
			if (d !== e.data) begin
				$error("data_out: expected %0h, got %0h", e.data, d);
				failures++;
			end
			if (f !== e.fill) begin
				$error("fill_level: expected %0d, got %0d", e.fill, f);
				failures++;
			end
			if (l !== e.last) begin
				$error("last: expected %0d, got %0d", e.last, l);
				failures++;
			end
		endfunction

		function void flag_leftovers();
			if (due_q.size() != 0) begin
				$error("%0d results never arrived", due_q.size());
				failures += due_q.size();
			end
		endfunction

		function int pending();
			return due_q.size();
		endfunction
	endclass

endpackage

// ----- verif/multi_channel_byte_fifo_unit_tb.sv -----
`timescale 1ns / 100ps

// Drives commands into the channel FIFO on the slave side and checks every result
// transfer on the master side against a behavioural mirror of the channel table.
module multi_channel_byte_fifo_unit_tb;
	import mcbf_pkg::*;
	import channel_tracker_pkg::*;

	localparam int HOLD_CYCLES = 300;   // long receiver hold-off, stalls the block

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic [23:0] s_tdata  = '0;
	logic [1:0]  s_tuser  = '0;
	logic        m_tready = 1'b0;
	logic        s_tready;
	logic        m_tvalid;
	logic [23:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;

	// idling controls, set per phase by the stimulus process
	bit tx_gaps   = 1'b1;
	bit rx_stalls = 1'b1;
	bit hold_req  = 1'b0;
	int holds_done = 0;
	int cmd_seen[4];

	channel_result_tracker board;

	always #5 clk = ~clk;

	multi_channel_byte_fifo_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // [3:0] channel, [11:4] data_in, [18:12] read_len
		.s_tuser  (s_tuser),   // [1:0] cmd
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // [3:0] channel_out, [11:4] data_out, [20:12] fill_level
		.m_tuser  (m_tuser),   // [2:0] status
		.m_tlast  (m_tlast)
	);

	// One command transfer. Optionally drops valid for a short burst first; valid stays
	// high between back-to-back transfers so it is never lowered and raised in one step.
	task automatic send_command(cmd_t cmd, logic [3:0] ch, logic [7:0] din,
		logic [6:0] rlen);
		int gap;
		if (tx_gaps && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 6);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {5'd0, rlen, din, ch};
		do @(posedge clk); while (!s_tready);
		// transfer taken at this edge
		board.take_command(cmd, ch, din, rlen);
		cmd_seen[cmd]++;
	endtask

	// mostly an open channel, now and then any index (closed-channel noise)
	function automatic int pick_channel();
		int start;
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(0, 15);
		start = $urandom_range(0, 15);
		for (int k = 0; k < 16; k++) begin
			if (board.is_open_q[(start + k) % 16])
				return (start + k) % 16;
		end
		return $urandom_range(0, 15);
	endfunction

	task automatic random_command();
		int         roll;
		int         pick;
		logic [3:0] ch;
		logic [6:0] rlen;
		roll = $urandom_range(0, 99);
		ch   = 4'(pick_channel());
		pick = $urandom_range(0, 9);
		// burst length: mostly legal, some zero and some past the saturation point
		if (pick == 0)
			rlen = 7'd0;
		else if (pick == 1)
			rlen = 7'($urandom_range(65, 127));
		else
			rlen = 7'($urandom_range(1, MAX_BURST));
		if (roll < 8)
			send_command(CMD_ALLOC, 4'($urandom_range(0, 15)), 8'($urandom), rlen);
		else if (roll < 14)
			send_command(CMD_RELEASE, ch, 8'($urandom), rlen);
		else if (roll < 70)
			send_command(CMD_WRITE, ch, 8'($urandom), rlen);
		else
			send_command(CMD_READ, ch, 8'($urandom), rlen);
	endtask

	// Receiver: random stall bursts, plus a long hold-off on request counted here.
	initial begin : receiver
		int stall;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
				hold_req = 1'b0;
				holds_done++;
			end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
				stall = $urandom_range(1, 6);
				m_tready <= 1'b0;
				repeat (stall - 1) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Result monitor: values sampled at the edge, before any update of that step.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.match_result(m_tuser, m_tdata[3:0], m_tdata[11:4], m_tdata[20:12], m_tlast);
	end

	initial begin : watchdog
		#15_000_000;
		$display("multi_channel_byte_fifo_unit_tb failed");
		$finish;
	end

	initial begin : stimulus
		int waited;
		board = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: closed-channel access, empty read, zero and oversized lengths,
		// lowest-free allocation and release of an already closed channel.
		send_command(CMD_READ, 4'd0, 8'h00, 7'd1);
		send_command(CMD_WRITE, 4'hF, 8'hFF, 7'h7F);
		send_command(CMD_RELEASE, 4'hA, 8'h55, 7'd64);
		send_command(CMD_ALLOC, 4'hF, 8'hFF, 7'h7F);
		send_command(CMD_READ, 4'd0, 8'h00, 7'h7F);
		send_command(CMD_WRITE, 4'd0, 8'h00, 7'd0);
		send_command(CMD_WRITE, 4'd0, 8'hFF, 7'd0);
		send_command(CMD_WRITE, 4'd0, 8'h5A, 7'd0);
		send_command(CMD_WRITE, 4'd0, 8'hA5, 7'd0);
		send_command(CMD_READ, 4'd0, 8'h00, 7'd0);
		send_command(CMD_READ, 4'd0, 8'h00, 7'h7F);
		send_command(CMD_READ, 4'd0, 8'h00, 7'd64);
		send_command(CMD_ALLOC, 4'd0, 8'h00, 7'd0);
		send_command(CMD_RELEASE, 4'd0, 8'h00, 7'd0);
		send_command(CMD_ALLOC, 4'd0, 8'h00, 7'd0);
		send_command(CMD_RELEASE, 4'd1, 8'h00, 7'd0);
		send_command(CMD_RELEASE, 4'd1, 8'h00, 7'd0);

		// allocate past the table size: the last few report no free channel
		repeat (17) send_command(CMD_ALLOC, 4'd0, 8'h00, 7'd0);
		send_command(CMD_WRITE, 4'hF, 8'hFF, 7'h7F);
		send_command(CMD_READ, 4'hF, 8'h00, 7'h7F);

		// Fill one ring to the brim, overflow it, drain partly, wrap and drain fully.
		repeat (RING_DEPTH) send_command(CMD_WRITE, 4'd7, 8'($urandom), 7'd1);
		repeat (2) send_command(CMD_WRITE, 4'd7, 8'($urandom), 7'd1);
		send_command(CMD_READ, 4'd7, 8'h00, 7'h7F);
		send_command(CMD_READ, 4'd7, 8'h00, 7'd100);
		repeat (20) send_command(CMD_WRITE, 4'd7, 8'($urandom), 7'd1);
		repeat (3) send_command(CMD_READ, 4'd7, 8'h00, 7'd64);
		send_command(CMD_READ, 4'd7, 8'h00, 7'd64);

		// free about half the table for the random part
		for (int c = 0; c < 16; c++) begin
			if ($urandom_range(0, 1))
				send_command(CMD_RELEASE, 4'(c), 8'h00, 7'd1);
		end

		// Random part in blocks with varying idling; one block holds the receiver
		// off while the sender keeps offering; the last block runs without gaps.
		for (int blk = 0; blk < 8; blk++) begin
			if (blk == 7) begin
				tx_gaps   = 1'b0;
				rx_stalls = 1'b0;
			end else begin
				{tx_gaps, rx_stalls} = 2'($urandom_range(0, 3));
			end
			if (blk == 3) begin
				tx_gaps  = 1'b0;
				hold_req = 1'b1;
			end
			repeat (10) random_command();
		end
		s_tvalid <= 1'b0;

		waited = 0;
		while (board.pending() > 0 && waited < 200_000) begin
			@(posedge clk);
			waited++;
		end
		repeat (20) @(posedge clk);
		board.flag_leftovers();

		$display("covered %0d commands (%0d allocate, %0d release, %0d write, %0d read), %0d results",
			cmd_seen[CMD_ALLOC] + cmd_seen[CMD_RELEASE] + cmd_seen[CMD_WRITE] + cmd_seen[CMD_READ],
			cmd_seen[CMD_ALLOC], cmd_seen[CMD_RELEASE], cmd_seen[CMD_WRITE], cmd_seen[CMD_READ],
			board.matched);
		$display("status mix: ok %0d, no free %0d, not open %0d, full %0d, empty %0d; hold-offs %0d",
			board.status_hits[STAT_OK], board.status_hits[STAT_NO_FREE],
			board.status_hits[STAT_NOT_OPEN], board.status_hits[STAT_FULL],
			board.status_hits[STAT_EMPTY], holds_done);
		if (board.failures == 0)
			$display("multi_channel_byte_fifo_unit_tb passed");
		else
			$display("multi_channel_byte_fifo_unit_tb failed");
		$finish;
	end

endmodule
